// ===== design/sps_pkg.sv =====
package sps_pkg;

    // widths of the fixed-point formats
    localparam int COUNT_BITS = 16;
    localparam int POS_W      = 32;
    localparam int COST_W     = 40;
    localparam int RATIO_W    = 16;
    localparam int AREA_W     = 51;
    localparam int NCNT_W     = COUNT_BITS + 1;
    localparam int MUL_W      = (NCNT_W > 32) ? NCNT_W : 32;
    localparam int PSUM_W     = RATIO_W + NCNT_W + 1;
    localparam int RAW_W      = RATIO_W + NCNT_W + 4;
    localparam int BIAS_A_W   = ((RAW_W + 2 + 7) / 8) * 8;
    localparam int BIAS_W     = (BIAS_A_W > COST_W + 8) ? BIAS_A_W : COST_W + 8;
    localparam int BIAS_STEPS = BIAS_W / 8;
    localparam int BCNT_W     = $clog2(BIAS_STEPS + 1);
    localparam int TC_W       = 16;
    localparam int TC_EXT_W   = (COUNT_BITS > TC_W) ? COUNT_BITS : TC_W;
    localparam int ONE_Q16    = 65536;
    localparam logic [3:0] BIAS_DEN = 4'd5;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // event queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // event kinds
    localparam logic [1:0] KIND_END   = 2'd0;
    localparam logic [1:0] KIND_PLANE = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRI_COUNT = 3'd7;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [1:0]              event_kind;
        logic                    last_event;
    } event_t;

    typedef struct packed {
        logic [COST_W-1:0]       min_cost;
        logic signed [POS_W-1:0] best_position;
        logic                    plane_side;
        logic                    found;
    } result_t;

    typedef struct packed {
        event_t ev;
        logic   skip;
    } front_item_t;

    typedef struct packed {
        logic [5:0][POS_W-1:0] bound;
        logic [1:0]            axis;
        logic [TC_W-1:0]       tri_count;
        logic                  tc_load;
    } cfg_t;

endpackage

// ===== design/sah_split_plane_sweep.sv =====
// channel   direction  handshake            payload
// events    in         push / full          sweep_event (position, kind, last mark)
// results   out        pop / empty          sweep_result (cost, position, side, found)
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an event that does not close a group passes fetch and apply; one that closes a group
// also runs close, the nine area products on the shared multiplier,
// the two 16-bit ratio divisions, the four cost products,
// the divide by five for each biased cost, and then decide before apply
// the last event then loads the result, and waits for pop while the result register is full
// reset clears the sweep and config; the event queue holds 4 entries
// and the result register holds one result while new events keep arriving
module sah_split_plane_sweep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sps_pkg::event_t               sweep_event,
    output logic                          empty,
    input  logic                          pop,
    output sps_pkg::result_t              sweep_result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import sps_pkg::*;

    cfg_t        cfg;
    logic        q_valid;
    logic        q_pop;
    front_item_t q_item;

    // configuration registers
    sps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // event intake and queue
    sps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sweep_event (sweep_event),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    // group scoring sequencer
    sps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .empty        (empty),
        .pop          (pop),
        .sweep_result (sweep_result)
    );

endmodule

// ===== design/sps_cfg.sv =====
module sps_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    output sps_pkg::cfg_t                    cfg
);
    import sps_pkg::*;

    logic [5:0][POS_W-1:0] bound_reg;
    logic [1:0]            axis_reg;
    logic [TC_W-1:0]       tc_reg;
    logic                  tc_load_reg;

    assign cfg_ready = 1'b1;

    // register file, a transfer writes one entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg   <= '0;
            axis_reg    <= '0;
            tc_reg      <= '0;
            tc_load_reg <= 1'b0;
        end
        else
        begin
            tc_load_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MIN_X, CFG_MAX_X, CFG_MIN_Y, CFG_MAX_Y, CFG_MIN_Z, CFG_MAX_Z:
                    begin
                        bound_reg[cfg_index] <= cfg_data;
                    end
                    CFG_AXIS:
                    begin
                        axis_reg <= cfg_data[1:0];
                    end
                    CFG_TRI_COUNT:
                    begin
                        tc_reg      <= cfg_data[TC_W-1:0];
                        tc_load_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign cfg.bound     = bound_reg;
    assign cfg.axis      = axis_reg;
    assign cfg.tri_count = tc_reg;
    assign cfg.tc_load   = tc_load_reg;

endmodule

// ===== design/sps_front.sv =====
module sps_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sps_pkg::event_t       sweep_event,
    output logic                  q_valid,
    input  logic                  q_pop,
    output sps_pkg::front_item_t  q_item
);
    import sps_pkg::*;

    front_item_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW:0]      count_reg;
    logic                  do_push;
    logic                  do_pop;
    front_item_t           item_in;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // classify: an event of unknown kind only carries its last mark
    always_comb
    begin
        item_in.ev   = sweep_event;
        item_in.skip = (sweep_event.event_kind == KIND_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    assign q_item = mem[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/sps_back.sv =====
module sps_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sps_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  sps_pkg::front_item_t  q_item,
    output logic                  empty,
    input  logic                  pop,
    output sps_pkg::result_t      sweep_result
);
    import sps_pkg::*;

    typedef enum logic [11:0] {
        S_FETCH  = 12'b000000000001,
        S_APPLY  = 12'b000000000010,
        S_CINIT  = 12'b000000000100,
        S_AMUL   = 12'b000000001000,
        S_AACC   = 12'b000000010000,
        S_DSTART = 12'b000000100000,
        S_DSTEP  = 12'b000001000000,
        S_SMUL   = 12'b000010000000,
        S_SACC   = 12'b000100000000,
        S_BIAS   = 12'b001000000000,
        S_DECIDE = 12'b010000000000,
        S_EMIT   = 12'b100000000000
    } state_t;

    localparam logic [1:0] BOX_TOTAL = 2'd0;
    localparam logic [1:0] BOX_LEFT  = 2'd1;
    localparam logic [1:0] BOX_RIGHT = 2'd2;

    state_t                   state_reg, state_next;
    front_item_t              ev_reg;
    cnt_t                     lc_reg, rc_reg, ge_reg, gp_reg, gb_reg;
    logic signed [POS_W-1:0]  gpos_reg;
    logic [1:0]               glk_reg;
    logic                     open_reg;
    logic                     final_reg;
    logic [COST_W-1:0]        min_cost_reg;
    logic signed [POS_W-1:0]  best_pos_reg;
    logic                     plane_side_reg;
    logic [1:0]               box_reg, pair_reg;
    logic [2*MUL_W-1:0]       prod_reg;
    logic [AREA_W-1:0]        area_t_reg, area_l_reg, area_r_reg;
    logic                     sel_reg;
    logic [AREA_W:0]          rem_reg;
    logic [RATIO_W-1:0]       quo_reg, pl_reg, pr_reg;
    logic [3:0]               dcnt_reg;
    logic [1:0]               j_reg;
    logic [PSUM_W-1:0]        sum_reg;
    logic [BIAS_W-1:0]        dv_reg;
    logic [2:0]               drem_reg;
    logic [BCNT_W-1:0]        bcnt_reg;
    logic [COST_W-1:0]        cl_reg, cr_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic [1:0]               ax_sel;
    logic [2:0][31:0]         ext;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [AREA_W-1:0]        area_term;
    logic [NCNT_W-1:0]        nl_a, rc_p;
    logic                     need_close;
    logic [AREA_W-1:0]        div_num;
    logic [AREA_W:0]          div_shift;
    logic                     div_ge;
    logic [BIAS_W-1:0]        raw_cost;
    logic                     bias_need;
    logic [BIAS_W-1:0]        dv_step;
    logic [2:0]               drem_step;
    logic [COST_W-1:0]        cl_cr_min;
    logic                     side_pick;

    function automatic logic [31:0] extent(input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
        logic signed [32:0] d;
        d = 33'(hi) - 33'(lo);
        return (hi > lo) ? d[31:0] : 32'd0;
    endfunction

    function automatic cnt_t cnt_add(input cnt_t a, input cnt_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic cnt_t cnt_sub(input cnt_t a, input cnt_t b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic cnt_t load_count(input logic [TC_W-1:0] v);
        logic [TC_EXT_W-1:0] v_ext, max_ext;
        v_ext   = TC_EXT_W'(v);
        max_ext = TC_EXT_W'({COUNT_BITS{1'b1}});
        return (v_ext > max_ext) ? '1 : v_ext[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COST_W-1:0] sat_cost(input logic [BIAS_W-1:0] v);
        return (|v[BIAS_W-1:COST_W]) ? COST_MAX : v[COST_W-1:0];
    endfunction

    // axis select, code three behaves as z
    always_comb
    begin
        case (cfg.axis)
            2'd0:    ax_sel = 2'd0;
            2'd1:    ax_sel = 2'd1;
            default: ax_sel = 2'd2;
        endcase
    end

    // extents of the box being measured, split plane replaces one bound
    always_comb
    begin
        logic signed [31:0] lo, hi;
        for (int a = 0; a < 3; a++)
        begin
            lo = cfg.bound[2*a];
            hi = cfg.bound[2*a+1];
            if (box_reg == BOX_LEFT && ax_sel == 2'(a))
            begin
                hi = gpos_reg;
            end
            if (box_reg == BOX_RIGHT && ax_sel == 2'(a))
            begin
                lo = gpos_reg;
            end
            ext[a] = extent(lo, hi);
        end
    end

    // child counts with the plane triangles charged to one side
    assign nl_a = {1'b0, lc_reg} + {1'b0, gp_reg};
    assign rc_p = {1'b0, rc_reg} + {1'b0, gp_reg};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_AMUL)
        begin
            case (pair_reg)
                2'd0:
                begin
                    mul_a = MUL_W'(ext[0]);
                    mul_b = MUL_W'(ext[1]);
                end
                2'd1:
                begin
                    mul_a = MUL_W'(ext[0]);
                    mul_b = MUL_W'(ext[2]);
                end
                default:
                begin
                    mul_a = MUL_W'(ext[1]);
                    mul_b = MUL_W'(ext[2]);
                end
            endcase
        end
        else
        begin
            case (j_reg)
                2'd0:
                begin
                    mul_a = MUL_W'(pl_reg);
                    mul_b = MUL_W'(nl_a);
                end
                2'd1:
                begin
                    mul_a = MUL_W'(pr_reg);
                    mul_b = MUL_W'(rc_reg);
                end
                2'd2:
                begin
                    mul_a = MUL_W'(pl_reg);
                    mul_b = MUL_W'(lc_reg);
                end
                default:
                begin
                    mul_a = MUL_W'(pr_reg);
                    mul_b = MUL_W'(rc_p);
                end
            endcase
        end
    end

    // one face-pair term, doubled when the third extent is non-zero
    always_comb
    begin
        logic [AREA_W-1:0] base;
        logic              single;
        base = AREA_W'(prod_reg[63:16]);
        case (pair_reg)
            2'd0:    single = (ext[2] == '0);
            2'd1:    single = (ext[1] == '0);
            default: single = (ext[0] == '0);
        endcase
        area_term = single ? base : (base << 1);
    end

    // group boundary test on the event at the head of the queue
    assign need_close = !q_item.skip && open_reg &&
                        ((q_item.ev.position != gpos_reg) ||
                         (q_item.ev.event_kind < glk_reg));

    // restoring division step for the area ratio
    assign div_num   = sel_reg ? area_r_reg : area_l_reg;
    assign div_shift = rem_reg << 1;
    assign div_ge    = (div_shift >= {1'b0, area_t_reg});

    // cost before bias: one plus three times the weighted counts
    always_comb
    begin
        logic [PSUM_W-1:0] s;
        s = sum_reg + PSUM_W'(prod_reg[RATIO_W+NCNT_W-1:0]);
        raw_cost = BIAS_W'(ONE_Q16) + (BIAS_W'(s) << 1) + BIAS_W'(s);
        bias_need = (j_reg == 2'd1) ? ((nl_a == '0) || (rc_reg == '0))
                                    : ((lc_reg == '0) || (rc_p == '0));
    end

    // divide by five, one byte of the dividend a cycle
    always_comb
    begin
        logic [3:0] r;
        logic [7:0] qb;
        r = {1'b0, drem_reg};
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[2:0], dv_reg[BIAS_W-8+i]};
            if (r >= BIAS_DEN)
            begin
                r     = r - BIAS_DEN;
                qb[i] = 1'b1;
            end
            else
            begin
                qb[i] = 1'b0;
            end
        end
        drem_step = r[2:0];
        dv_step   = {dv_reg[BIAS_W-9:0], qb};
    end

    // cheaper side, ties go right
    assign side_pick = !(cl_reg < cr_reg);
    assign cl_cr_min = side_pick ? cr_reg : cl_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_FETCH:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = need_close ? S_CINIT : S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (ev_reg.ev.last_event)
                begin
                    state_next = (!ev_reg.skip || open_reg) ? S_CINIT : S_EMIT;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_CINIT:
            begin
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                state_next = S_AACC;
            end
            S_AACC:
            begin
                if (pair_reg == 2'd2 && box_reg == BOX_RIGHT)
                begin
                    state_next = S_DSTART;
                end
                else
                begin
                    state_next = S_AMUL;
                end
            end
            S_DSTART:
            begin
                if (area_t_reg == '0 || div_num >= area_t_reg)
                begin
                    state_next = sel_reg ? S_SMUL : S_DSTART;
                end
                else
                begin
                    state_next = S_DSTEP;
                end
            end
            S_DSTEP:
            begin
                if (dcnt_reg == 4'd15)
                begin
                    state_next = sel_reg ? S_SMUL : S_DSTART;
                end
            end
            S_SMUL:
            begin
                state_next = S_SACC;
            end
            S_SACC:
            begin
                if (!j_reg[0])
                begin
                    state_next = S_SMUL;
                end
                else if (bias_need)
                begin
                    state_next = S_BIAS;
                end
                else
                begin
                    state_next = (j_reg == 2'd3) ? S_DECIDE : S_SMUL;
                end
            end
            S_BIAS:
            begin
                if (bcnt_reg == BCNT_W'(BIAS_STEPS - 1))
                begin
                    state_next = (j_reg == 2'd3) ? S_DECIDE : S_SMUL;
                end
            end
            S_DECIDE:
            begin
                state_next = final_reg ? S_EMIT : S_APPLY;
            end
            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    // datapath and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FETCH;
            ev_reg         <= '0;
            lc_reg         <= '0;
            rc_reg         <= '0;
            ge_reg         <= '0;
            gp_reg         <= '0;
            gb_reg         <= '0;
            gpos_reg       <= '0;
            glk_reg        <= '0;
            open_reg       <= 1'b0;
            final_reg      <= 1'b0;
            min_cost_reg   <= COST_MAX;
            best_pos_reg   <= '0;
            plane_side_reg <= 1'b0;
            box_reg        <= '0;
            pair_reg       <= '0;
            prod_reg       <= '0;
            area_t_reg     <= '0;
            area_l_reg     <= '0;
            area_r_reg     <= '0;
            sel_reg        <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            pl_reg         <= '0;
            pr_reg         <= '0;
            dcnt_reg       <= '0;
            j_reg          <= '0;
            sum_reg        <= '0;
            dv_reg         <= '0;
            drem_reg       <= '0;
            bcnt_reg       <= '0;
            cl_reg         <= '0;
            cr_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // result slot, freed by a transfer
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end

            // a new triangle count reloads the right side
            if (cfg.tc_load)
            begin
                rc_reg <= load_count(cfg.tri_count);
            end

            unique case (state_reg)
                S_FETCH:
                begin
                    if (q_valid)
                    begin
                        ev_reg    <= q_item;
                        final_reg <= 1'b0;
                    end
                end
                S_APPLY:
                begin
                    if (!ev_reg.skip)
                    begin
                        if (!open_reg)
                        begin
                            open_reg <= 1'b1;
                            gpos_reg <= ev_reg.ev.position;
                        end
                        ge_reg <= (ev_reg.ev.event_kind == KIND_END)
                                  ? cnt_add(open_reg ? ge_reg : '0, cnt_t'(1))
                                  : (open_reg ? ge_reg : '0);
                        gp_reg <= (ev_reg.ev.event_kind == KIND_PLANE)
                                  ? cnt_add(open_reg ? gp_reg : '0, cnt_t'(1))
                                  : (open_reg ? gp_reg : '0);
                        gb_reg <= (ev_reg.ev.event_kind == KIND_BEGIN)
                                  ? cnt_add(open_reg ? gb_reg : '0, cnt_t'(1))
                                  : (open_reg ? gb_reg : '0);
                        glk_reg <= ev_reg.ev.event_kind;
                    end
                    if (ev_reg.ev.last_event)
                    begin
                        final_reg <= 1'b1;
                    end
                end
                S_CINIT:
                begin
                    rc_reg     <= cnt_sub(cnt_sub(rc_reg, gp_reg), ge_reg);
                    box_reg    <= BOX_TOTAL;
                    pair_reg   <= '0;
                    area_t_reg <= '0;
                    area_l_reg <= '0;
                    area_r_reg <= '0;
                    sel_reg    <= 1'b0;
                end
                S_AMUL:
                begin
                    prod_reg <= mul_a * mul_b;
                end
                S_AACC:
                begin
                    case (box_reg)
                        BOX_TOTAL: area_t_reg <= area_t_reg + area_term;
                        BOX_LEFT:  area_l_reg <= area_l_reg + area_term;
                        default:   area_r_reg <= area_r_reg + area_term;
                    endcase
                    if (pair_reg == 2'd2)
                    begin
                        pair_reg <= '0;
                        if (box_reg != BOX_RIGHT)
                        begin
                            box_reg <= box_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pair_reg <= pair_reg + 1'b1;
                    end
                end
                S_DSTART:
                begin
                    rem_reg  <= {1'b0, div_num};
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                    j_reg    <= '0;
                    if (area_t_reg == '0 || div_num >= area_t_reg)
                    begin
                        if (sel_reg)
                        begin
                            pr_reg <= (area_t_reg == '0) ? '0 : '1;
                        end
                        else
                        begin
                            pl_reg <= (area_t_reg == '0) ? '0 : '1;
                        end
                        sel_reg <= 1'b1;
                    end
                end
                S_DSTEP:
                begin
                    rem_reg  <= div_ge ? (div_shift - {1'b0, area_t_reg}) : div_shift;
                    quo_reg  <= {quo_reg[RATIO_W-2:0], div_ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 4'd15)
                    begin
                        if (sel_reg)
                        begin
                            pr_reg <= {quo_reg[RATIO_W-2:0], div_ge};
                        end
                        else
                        begin
                            pl_reg <= {quo_reg[RATIO_W-2:0], div_ge};
                        end
                        sel_reg <= 1'b1;
                    end
                end
                S_SMUL:
                begin
                    prod_reg <= mul_a * mul_b;
                end
                S_SACC:
                begin
                    if (!j_reg[0])
                    begin
                        sum_reg <= PSUM_W'(prod_reg[RATIO_W+NCNT_W-1:0]);
                        j_reg   <= j_reg + 1'b1;
                    end
                    else if (bias_need)
                    begin
                        dv_reg   <= raw_cost << 2;
                        drem_reg <= '0;
                        bcnt_reg <= '0;
                    end
                    else
                    begin
                        if (j_reg == 2'd1)
                        begin
                            cl_reg <= sat_cost(raw_cost);
                        end
                        else
                        begin
                            cr_reg <= sat_cost(raw_cost);
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_BIAS:
                begin
                    dv_reg   <= dv_step;
                    drem_reg <= drem_step;
                    bcnt_reg <= bcnt_reg + 1'b1;
                    if (bcnt_reg == BCNT_W'(BIAS_STEPS - 1))
                    begin
                        if (j_reg == 2'd1)
                        begin
                            cl_reg <= sat_cost(dv_step);
                        end
                        else
                        begin
                            cr_reg <= sat_cost(dv_step);
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (cl_cr_min < min_cost_reg)
                    begin
                        min_cost_reg   <= cl_cr_min;
                        plane_side_reg <= side_pick;
                        best_pos_reg   <= gpos_reg;
                    end
                    lc_reg   <= cnt_add(cnt_add(lc_reg, gb_reg), gp_reg);
                    open_reg <= 1'b0;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.min_cost      <= min_cost_reg;
                        out_reg.best_position <= best_pos_reg;
                        out_reg.plane_side    <= plane_side_reg;
                        out_reg.found         <= (min_cost_reg < COST_MAX);
                        // fresh sweep
                        lc_reg         <= '0;
                        rc_reg         <= load_count(cfg.tri_count);
                        gpos_reg       <= '0;
                        ge_reg         <= '0;
                        gp_reg         <= '0;
                        gb_reg         <= '0;
                        glk_reg        <= '0;
                        open_reg       <= 1'b0;
                        min_cost_reg   <= COST_MAX;
                        best_pos_reg   <= '0;
                        plane_side_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign empty        = !out_valid_reg;
    assign sweep_result = out_reg;

endmodule
